/* hw/rtl/rpft_pkg.sv */
`default_nettype none
package rpft_pkg;

	localparam logic [1:0] VERDICT_FWD   = 2'd0;
	localparam logic [1:0] VERDICT_BAD   = 2'd1;
	localparam logic [1:0] VERDICT_STALE = 2'd2;
	localparam logic [1:0] VERDICT_POLL  = 2'd3;

	localparam logic [2:0] EV_REAR_CONFIRM = 3'd0;
	localparam logic [2:0] EV_REMOTE_SOS   = 3'd1;
	localparam logic [2:0] EV_PERSON       = 3'd2;
	localparam logic [2:0] EV_RADAR_CLEAR  = 3'd3;
	localparam logic [2:0] EV_RADAR_HEALTH = 3'd4;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_POLL   = 1'b1;

	localparam logic [1:0] CFG_REMOTE_NODE_ID = 2'd0;
	localparam logic [1:0] CFG_HEALTHY_CODE   = 2'd1;
	localparam logic [1:0] CFG_SESSION_TMO    = 2'd2;

	localparam logic [7:0]  RST_REMOTE_NODE_ID = 8'd1;
	localparam logic [15:0] RST_HEALTHY_CODE   = 16'd1;
	localparam logic [31:0] RST_SESSION_TMO    = 32'd3000;

	localparam logic [14:0] SEQ_HALF_MAX = 15'h7fff;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_time_ms;
		logic        frame_ok;
		logic [7:0]  node_id;
		logic [7:0]  flags_byte;
		logic [2:0]  event_code;
		logic [15:0] packet_value;
		logic [15:0] sequence_num;
	} rpft_in_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [2:0]  event_kind;
		logic [15:0] out_sequence;
		logic [15:0] out_value;
		logic        radar_online;
		logic        radar_healthy;
		logic        person_seen;
		logic [15:0] distance_cm;
		logic [31:0] packet_age_ms;
	} rpft_out_t;

	typedef struct packed {
		logic [7:0]  remote_node_id;
		logic [15:0] healthy_code;
		logic [31:0] session_timeout_ms;
	} rpft_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/rpft_core.sv */
`default_nettype none
module rpft_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire rpft_pkg::rpft_in_t  item,
	input  wire rpft_pkg::rpft_cfg_t cfg,
	output rpft_pkg::rpft_out_t      result
);
	import rpft_pkg::*;

	logic        session_valid_q;
	logic [15:0] last_seq_q;
	logic [31:0] last_time_q;
	logic        healthy_q;
	logic        person_q;
	logic [15:0] distance_q;

	logic        session_valid_d;
	logic [15:0] last_seq_d;
	logic [31:0] last_time_d;
	logic        healthy_d;
	logic        person_d;
	logic [15:0] distance_d;

	logic        value_ok;
	logic        is_radar;
	logic        fresh;
	logic [31:0] old_age;
	logic [15:0] seq_diff;
	logic [1:0]  verdict;
	logic [31:0] new_age;
	logic        online;

	always_comb begin
		unique case (item.event_code)
			EV_REAR_CONFIRM, EV_REMOTE_SOS: value_ok = (item.packet_value == 16'd1);
			EV_PERSON:                      value_ok = 1'b1;
			EV_RADAR_CLEAR:                 value_ok = (item.packet_value == 16'd0);
			EV_RADAR_HEALTH:                value_ok = (item.packet_value <= cfg.healthy_code);
			default:                        value_ok = 1'b0;
		endcase
	end

	assign is_radar = (item.event_code == EV_PERSON) || (item.event_code == EV_RADAR_CLEAR)
		|| (item.event_code == EV_RADAR_HEALTH);
	assign old_age  = item.now_time_ms - last_time_q;
	assign seq_diff = item.sequence_num - last_seq_q;
	assign fresh    = !session_valid_q || (old_age > cfg.session_timeout_ms)
		|| ((seq_diff != 16'd0) && (seq_diff <= {1'b0, SEQ_HALF_MAX}));

	always_comb begin
		session_valid_d = session_valid_q;
		last_seq_d      = last_seq_q;
		last_time_d     = last_time_q;
		healthy_d       = healthy_q;
		person_d        = person_q;
		distance_d      = distance_q;
		priority if (item.kind == KIND_POLL) begin
			verdict = VERDICT_POLL;
		end else if (!item.frame_ok || (item.node_id != cfg.remote_node_id)
				|| (item.flags_byte != 8'd0) || !value_ok) begin
			verdict = VERDICT_BAD;
		end else if (is_radar && !fresh) begin
			verdict = VERDICT_STALE;
		end else begin
			verdict = VERDICT_FWD;
			if (is_radar) begin
				session_valid_d = 1'b1;
				last_seq_d      = item.sequence_num;
				last_time_d     = item.now_time_ms;
				priority if (item.event_code == EV_PERSON) begin
					healthy_d  = 1'b1;
					person_d   = 1'b1;
					distance_d = item.packet_value;
				end else if (item.event_code == EV_RADAR_CLEAR) begin
					healthy_d  = 1'b1;
					person_d   = 1'b0;
					distance_d = 16'd0;
				end else begin
					healthy_d = (item.packet_value == cfg.healthy_code);
					if (item.packet_value != cfg.healthy_code) begin
						person_d   = 1'b0;
						distance_d = 16'd0;
					end
				end
			end
		end
	end

	assign new_age = session_valid_d ? (item.now_time_ms - last_time_d) : '1;
	assign online  = session_valid_d && (new_age <= cfg.session_timeout_ms);

	always_comb begin
		result.verdict       = verdict;
		result.event_kind    = (verdict == VERDICT_FWD) ? item.event_code : 3'd0;
		result.out_sequence  = (verdict == VERDICT_FWD) ? item.sequence_num : 16'd0;
		result.out_value     = (verdict == VERDICT_FWD) ? item.packet_value : 16'd0;
		result.radar_online  = online;
		result.radar_healthy = online && healthy_d;
		result.person_seen   = online && person_d;
		result.distance_cm   = online ? distance_d : 16'd0;
		result.packet_age_ms = new_age;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_valid_q <= 1'b0;
			last_seq_q      <= 16'd0;
			last_time_q     <= 32'd0;
			healthy_q       <= 1'b0;
			person_q        <= 1'b0;
			distance_q      <= 16'd0;
		end else if (fire) begin
			session_valid_q <= session_valid_d;
			last_seq_q      <= last_seq_d;
			last_time_q     <= last_time_d;
			healthy_q       <= healthy_d;
			person_q        <= person_d;
			distance_q      <= distance_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/radar_packet_filter_tracker.sv */
`default_nettype none
// Radar packet filter and status tracker. Each input beat (packet or status poll)
// yields exactly one result beat, in order. An input beat is captured in an input
// register, evaluated combinationally against the tracker state and written to the
// result register once that register is free or being taken, so a new beat is taken
// every cycle unless the block stalls. It stalls only when both the input and the
// result register are full and the result is not being taken.
// Configuration writes are taken at any time (cfg_ready is always high) and should
// only be issued while no beat is in flight; index 3 is ignored.
module radar_packet_filter_tracker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rpft_pkg::rpft_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rpft_pkg::rpft_out_t     out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import rpft_pkg::*;

	rpft_cfg_t cfg_q;
	rpft_in_t  item_s1;
	logic      valid_s1;
	rpft_out_t result;
	logic      advance;
	logic      fire;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remote_node_id     <= RST_REMOTE_NODE_ID;
			cfg_q.healthy_code       <= RST_HEALTHY_CODE;
			cfg_q.session_timeout_ms <= RST_SESSION_TMO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REMOTE_NODE_ID: cfg_q.remote_node_id     <= cfg_data[7:0];
				CFG_HEALTHY_CODE:   cfg_q.healthy_code       <= cfg_data[15:0];
				CFG_SESSION_TMO:    cfg_q.session_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (fire)
			out_data <= result;
	end

	rpft_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule
`default_nettype wire

/* hw/rtl/rpft_checker.sv */
`default_nettype none
module rpft_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire rpft_pkg::rpft_out_t out_data
);
	import rpft_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_not_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.verdict != VERDICT_FWD) |->
		(out_data.event_kind == 3'd0) && (out_data.out_sequence == 16'd0)
		&& (out_data.out_value == 16'd0))
		else $error("event fields set on a beat that was not forwarded");

	a_offline_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.radar_online |->
		!out_data.radar_healthy && !out_data.person_seen && (out_data.distance_cm == 16'd0))
		else $error("status shown while radar offline");

	a_fwd_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.verdict == VERDICT_FWD) |->
		(out_data.event_kind <= EV_RADAR_HEALTH))
		else $error("unknown event forwarded");

endmodule

bind radar_packet_filter_tracker rpft_checker u_rpft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
